/* rtl/core/ax25_hdlc_tx_framer_macros.svh */
// Assertion macros shared by the AX.25 transmit framer RTL.
`ifndef AX25_HDLC_TX_FRAMER_MACROS_SVH
`define AX25_HDLC_TX_FRAMER_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication, clocked on clk, off while in reset
`define AX25_ASSERT_IMM(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication
`define AX25_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define AX25_ASSERT_IMM(lbl, ante, cons, msg)
`define AX25_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

/* rtl/core/ax25tx_pkg.sv */
// Types, constants and helper functions for the AX.25 HDLC transmit framer.
package ax25tx_pkg;

	parameter int unsigned MAX_FLAGS  = 16;
	parameter int unsigned FLAG_CNT_W = $clog2(MAX_FLAGS + 1);

	parameter int unsigned CFG_W     = 5;
	parameter int unsigned CFG_IDX_W = 1;
	parameter logic [CFG_IDX_W-1:0] REG_PREAMBLE  = 1'd0;
	parameter logic [CFG_IDX_W-1:0] REG_POSTAMBLE = 1'd1;
	parameter logic [CFG_W-1:0]     CFG_RESET     = 5'd8;

	parameter logic [7:0]  FLAG_BYTE = 8'h7E;
	parameter logic [15:0] CRC_INIT  = 16'hFFFF;
	parameter logic [15:0] CRC_POLY  = 16'h8408;

	// stuffed chunk: 8 data bits plus up to two inserted zeros
	parameter int unsigned CHUNK_W = 10;
	parameter int unsigned LEN_W   = 4;
	// leftover bits after one byte is taken from a merged chunk
	parameter int unsigned PEND_W  = 9;
	parameter int unsigned CNT_W   = 4;
	parameter int unsigned MERGE_W = 17;

	typedef struct packed {
		logic [7:0] body_byte;
		logic       frame_end;
	} in_t;

	typedef struct packed {
		logic [7:0] line_byte;
		logic       run_last;
		logic       frame_done;
	} out_t;

	typedef enum logic [5:0] {
		P_PRE  = 6'b000001,
		P_BODY = 6'b000010,
		P_FCS0 = 6'b000100,
		P_FCS1 = 6'b001000,
		P_POST = 6'b010000,
		P_PAD  = 6'b100000
	} phase_t;

	typedef struct packed {
		logic               step;
		logic               load;
		logic               pad;
		logic [CHUNK_W-1:0] chunk;
		logic [LEN_W-1:0]   len;
	} pk_ctl_t;

	typedef struct packed {
		logic             drain;
		logic [7:0]       line_byte;
		logic [CNT_W-1:0] cnt_next;
	} pk_stat_t;

	typedef struct packed {
		logic upd;
		logic clr;
	} crc_ctl_t;

	typedef struct packed {
		logic [CHUNK_W-1:0] bits;
		logic [LEN_W-1:0]   len;
		logic [2:0]         ones;
	} stuff_t;

	// zero insertion after five ones, LSB first; run count carried in and out
	function automatic stuff_t stuff_byte(input logic [7:0] b, input logic [2:0] ones_in);
		stuff_t r;
		logic [2:0] ones;
		logic [LEN_W-1:0] pos;
		r.bits = '0;
		ones = ones_in;
		pos = '0;
		for (int k = 0; k < 8; k++) begin
			r.bits[pos] = b[k];
			pos = pos + LEN_W'(1);
			if (b[k]) begin
				if (ones == 3'd4) begin
					pos = pos + LEN_W'(1);
					ones = '0;
				end else begin
					ones = ones + 3'd1;
				end
			end else begin
				ones = '0;
			end
		end
		r.len = pos;
		r.ones = ones;
		return r;
	endfunction

	// reflected CRC-16, one byte LSB first
	function automatic logic [15:0] crc_byte(input logic [15:0] c_in, input logic [7:0] b);
		logic [15:0] c;
		c = c_in;
		for (int k = 0; k < 8; k++) begin
			if (c[0] ^ b[k])
				c = (c >> 1) ^ CRC_POLY;
			else
				c = c >> 1;
		end
		return c;
	endfunction

	function automatic logic [FLAG_CNT_W-1:0] sat_flags(input logic [CFG_W-1:0] v);
		if (32'(v) > MAX_FLAGS)
			return FLAG_CNT_W'(MAX_FLAGS);
		else
			return FLAG_CNT_W'(v);
	endfunction

endpackage

/* rtl/core/ax25tx_crc.sv */
// Running frame check sequence register.
`include "ax25_hdlc_tx_framer_macros.svh"
module ax25tx_crc (
	input  logic                clk,
	input  logic                arst_n,
	input  ax25tx_pkg::crc_ctl_t ctl,
	input  logic [7:0]          data,
	output logic [15:0]         crc
);

	logic [15:0] crc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q <= ax25tx_pkg::CRC_INIT;
		end else if (ctl.clr) begin
			crc_q <= ax25tx_pkg::CRC_INIT;
		end else if (ctl.upd) begin
			crc_q <= ax25tx_pkg::crc_byte(crc_q, data);
		end
	end

	assign crc = crc_q;

	`AX25_ASSERT_NXT(a_crc_clear, ctl.clr, crc_q == ax25tx_pkg::CRC_INIT, "crc not reinitialized")

endmodule

/* rtl/core/ax25tx_packer.sv */
// Line bit packer: merges stuffed chunks and hands out one byte per step.
`include "ax25_hdlc_tx_framer_macros.svh"
module ax25tx_packer (
	input  logic                 clk,
	input  logic                 arst_n,
	input  ax25tx_pkg::pk_ctl_t  ctl,
	output ax25tx_pkg::pk_stat_t stat
);

	logic [ax25tx_pkg::PEND_W-1:0]  pend_q, pend_n;
	logic [ax25tx_pkg::CNT_W-1:0]   cnt_q, cnt_n;
	logic [ax25tx_pkg::MERGE_W-1:0] merged;
	logic [ax25tx_pkg::CNT_W:0]     total;

	always_comb begin
		merged = ax25tx_pkg::MERGE_W'(pend_q)
			| (ax25tx_pkg::MERGE_W'(ctl.chunk) << cnt_q);
		total = (ax25tx_pkg::CNT_W+1)'(cnt_q) + (ax25tx_pkg::CNT_W+1)'(ctl.len);
		stat.drain = cnt_q >= ax25tx_pkg::CNT_W'(8);
		if (stat.drain) begin
			// a full byte is already waiting
			stat.line_byte = pend_q[7:0];
			pend_n = pend_q >> 8;
			cnt_n = cnt_q - ax25tx_pkg::CNT_W'(8);
		end else if (ctl.load) begin
			stat.line_byte = merged[7:0];
			pend_n = merged[ax25tx_pkg::MERGE_W-1:8];
			cnt_n = ax25tx_pkg::CNT_W'(total - (ax25tx_pkg::CNT_W+1)'(8));
		end else begin
			// closing byte, upper bits are already zero
			stat.line_byte = pend_q[7:0];
			pend_n = '0;
			cnt_n = '0;
		end
		stat.cnt_next = cnt_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
			cnt_q <= '0;
		end else if (ctl.step) begin
			pend_q <= pend_n;
			cnt_q <= cnt_n;
		end
	end

	`AX25_ASSERT_IMM(a_cnt_bound, 1'b1, cnt_q <= ax25tx_pkg::CNT_W'(ax25tx_pkg::PEND_W), "bit count overrun")
	`AX25_ASSERT_NXT(a_pad_empty, ctl.step && ctl.pad && !stat.drain, cnt_q == '0 && pend_q == '0, "pad left bits")

endmodule

/* rtl/core/ax25tx_seq.sv */
// Frame sequencer: flag, body, FCS and pad phases, stuffing and end marks.
`include "ax25_hdlc_tx_framer_macros.svh"
module ax25tx_seq (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic                         item_vld,
	input  ax25tx_pkg::in_t              item,
	input  logic                         advance,
	input  logic [ax25tx_pkg::CFG_W-1:0] pre_cfg,
	input  logic [ax25tx_pkg::CFG_W-1:0] post_cfg,
	input  logic [15:0]                  crc,
	input  ax25tx_pkg::pk_stat_t         stat,
	output ax25tx_pkg::pk_ctl_t          ctl,
	output ax25tx_pkg::crc_ctl_t         crc_ctl,
	output ax25tx_pkg::out_t             result,
	output logic                         step,
	output logic                         done
);

	ax25tx_pkg::phase_t phase_q, phase_n;
	logic [ax25tx_pkg::FLAG_CNT_W-1:0] flag_cnt_q, flag_n, pre_n, post_n;
	logic [2:0] ones_q;
	logic       in_frame_q, in_frame_eff;
	logic       consumed, stuffing, frame_close;
	logic [7:0] src;
	ax25tx_pkg::stuff_t st;

	assign pre_n  = ax25tx_pkg::sat_flags(pre_cfg);
	assign post_n = ax25tx_pkg::sat_flags(post_cfg);
	assign step   = item_vld && advance;

	always_comb begin
		src = item.body_byte;
		stuffing = 1'b0;
		ctl.load = 1'b1;
		ctl.pad = 1'b0;
		case (phase_q)
			ax25tx_pkg::P_PRE, ax25tx_pkg::P_POST: begin
				src = ax25tx_pkg::FLAG_BYTE;
			end
			ax25tx_pkg::P_BODY: begin
				src = item.body_byte;
				stuffing = 1'b1;
			end
			ax25tx_pkg::P_FCS0: begin
				src = ~crc[7:0];
				stuffing = 1'b1;
			end
			ax25tx_pkg::P_FCS1: begin
				src = ~crc[15:8];
				stuffing = 1'b1;
			end
			ax25tx_pkg::P_PAD: begin
				ctl.load = 1'b0;
				ctl.pad = 1'b1;
			end
			default: begin
				ctl.load = 1'b0;
				ctl.pad = 1'b1;
			end
		endcase
		st = ax25tx_pkg::stuff_byte(src, ones_q);
		ctl.step = step;
		if (stuffing) begin
			ctl.chunk = st.bits;
			ctl.len = st.len;
		end else begin
			// flags go out unstuffed
			ctl.chunk = ax25tx_pkg::CHUNK_W'(src);
			ctl.len = ax25tx_pkg::LEN_W'(8);
		end
	end

	assign consumed = step && !stat.drain && ctl.load;

	always_comb begin
		phase_n = phase_q;
		flag_n = flag_cnt_q;
		if (consumed) begin
			case (phase_q)
				ax25tx_pkg::P_PRE: begin
					flag_n = flag_cnt_q - ax25tx_pkg::FLAG_CNT_W'(1);
					if (flag_cnt_q == ax25tx_pkg::FLAG_CNT_W'(1))
						phase_n = ax25tx_pkg::P_BODY;
				end
				ax25tx_pkg::P_BODY: begin
					phase_n = item.frame_end ? ax25tx_pkg::P_FCS0 : ax25tx_pkg::P_PAD;
				end
				ax25tx_pkg::P_FCS0: begin
					phase_n = ax25tx_pkg::P_FCS1;
				end
				ax25tx_pkg::P_FCS1: begin
					if (post_n != '0) begin
						phase_n = ax25tx_pkg::P_POST;
						flag_n = post_n;
					end else begin
						phase_n = ax25tx_pkg::P_PAD;
					end
				end
				ax25tx_pkg::P_POST: begin
					flag_n = flag_cnt_q - ax25tx_pkg::FLAG_CNT_W'(1);
					if (flag_cnt_q == ax25tx_pkg::FLAG_CNT_W'(1))
						phase_n = ax25tx_pkg::P_PAD;
				end
				default: begin
					phase_n = ax25tx_pkg::P_PAD;
				end
			endcase
		end
	end

	// item ends once no chunk is left and the bits held back are its own
	assign done = step && (phase_n == ax25tx_pkg::P_PAD)
		&& (item.frame_end ? (stat.cnt_next == '0)
			: (stat.cnt_next < ax25tx_pkg::CNT_W'(8)));
	assign frame_close  = done && item.frame_end;
	assign in_frame_eff = in_frame_q && !frame_close;

	assign crc_ctl.upd = consumed && (phase_q == ax25tx_pkg::P_BODY);
	assign crc_ctl.clr = frame_close;

	assign result.line_byte  = stat.line_byte;
	assign result.run_last   = done;
	assign result.frame_done = frame_close;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= ax25tx_pkg::P_PAD;
			flag_cnt_q <= '0;
			ones_q <= '0;
			in_frame_q <= 1'b0;
		end else begin
			if (frame_close) begin
				in_frame_q <= 1'b0;
				ones_q <= '0;
			end else if (consumed && stuffing) begin
				ones_q <= st.ones;
			end
			if (start) begin
				in_frame_q <= 1'b1;
				flag_cnt_q <= pre_n;
				if (!in_frame_eff && pre_n != '0)
					phase_q <= ax25tx_pkg::P_PRE;
				else
					phase_q <= ax25tx_pkg::P_BODY;
			end else if (step) begin
				phase_q <= phase_n;
				flag_cnt_q <= flag_n;
			end
		end
	end

	`AX25_ASSERT_NXT(a_frame_close, frame_close && !start, !in_frame_q && ones_q == '0, "frame state not closed")

endmodule

/* rtl/core/ax25_hdlc_tx_framer.sv */
// Top level of the AX.25 HDLC transmit framer: ports, config, item and result registers.
// A request passes the item register, then its first line byte passes the result register.
// Throughput: one line byte per cycle while out_ready does not hold the result register;
// a frame's line bytes are its preamble flags, stuffed body and FCS bytes, postamble flags and any pad byte.
// Reset (arst_n low, async): frame state, packer, handshakes clear; CRC all ones; flags 8.
`include "ax25_hdlc_tx_framer_macros.svh"
module ax25_hdlc_tx_framer (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  ax25tx_pkg::in_t                  in_data,
	output logic                             out_valid,
	input  logic                             out_ready,
	output ax25tx_pkg::out_t                 out_data,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [ax25tx_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [ax25tx_pkg::CFG_W-1:0]     cfg_data
);

	// flag counts; only rewrite them between frames (the block itself does not enforce it)
	logic [ax25tx_pkg::CFG_W-1:0] pre_q, post_q;

	// request under work; the next one may enter in the cycle this one ends
	ax25tx_pkg::in_t item_s1;
	logic            item_vld_s1;

	// result register parts the sequencer from the output side
	ax25tx_pkg::out_t out_q;
	logic             out_vld_q;

	logic                 accept, advance, step, done;
	logic [15:0]          crc;
	ax25tx_pkg::pk_ctl_t  pk_ctl;
	ax25tx_pkg::pk_stat_t pk_stat;
	ax25tx_pkg::crc_ctl_t crc_ctl;
	ax25tx_pkg::out_t     result;

	assign cfg_ready = 1'b1;
	assign advance   = !out_vld_q || out_ready;
	assign in_ready  = !item_vld_s1 || done;
	assign accept    = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pre_q <= ax25tx_pkg::CFG_RESET;
			post_q <= ax25tx_pkg::CFG_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				ax25tx_pkg::REG_PREAMBLE:  pre_q <= cfg_data;
				ax25tx_pkg::REG_POSTAMBLE: post_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_vld_s1 <= 1'b0;
		end else if (accept) begin
			item_vld_s1 <= 1'b1;
		end else if (done) begin
			item_vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept)
			item_s1 <= in_data;
	end

	// every sequencer step emits exactly one line byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (step) begin
			out_vld_q <= 1'b1;
		end else if (out_ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step)
			out_q <= result;
	end

	assign out_valid = out_vld_q;
	assign out_data  = out_q;

	ax25tx_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (accept),
		.item_vld (item_vld_s1),
		.item     (item_s1),
		.advance  (advance),
		.pre_cfg  (pre_q),
		.post_cfg (post_q),
		.crc      (crc),
		.stat     (pk_stat),
		.ctl      (pk_ctl),
		.crc_ctl  (crc_ctl),
		.result   (result),
		.step     (step),
		.done     (done)
	);

	ax25tx_packer u_packer (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (pk_ctl),
		.stat   (pk_stat)
	);

	ax25tx_crc u_crc (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (crc_ctl),
		.data   (item_s1.body_byte),
		.crc    (crc)
	);

	`AX25_ASSERT_NXT(a_item_held, item_vld_s1 && !done, item_vld_s1 && $stable(item_s1), "request dropped")

endmodule
